>>> rtl/flms_pkg.sv
// ----------------------------------------------------------------------------
// flms_pkg
// Shared types and constants for the farthest-point landmark selector.
// ----------------------------------------------------------------------------
package flms_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int MAX_LANDMARKS = 64;
    localparam int COORD_W       = 16;
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int LM_CNT_W      = 7;
    localparam int SLOT_W        = 6;
    localparam int DIST_W        = 33;
    localparam int SQ_W          = 32;
    localparam int PT_W          = 2 * COORD_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic                      last_point;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] landmark_index;
        logic             last_landmark;
    } out_item_t;

    // point travelling down the cell chain with its running nearest distance
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIST_W-1:0]         near_dist;
    } tok_t;

    typedef struct packed {
        logic                      clear;
        logic                      load;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_LOAD,
        S_STREAM,
        S_DECIDE,
        S_PUSH,
        S_ADOPT,
        S_FINAL
    } state_t;

endpackage

>>> rtl/flms_ram.sv
// ----------------------------------------------------------------------------
// flms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module flms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/flms_cell.sv
// ----------------------------------------------------------------------------
// flms_cell
// One landmark cell: holds a landmark, folds its squared distance into the
// running minimum of each passing point. Three register stages.
// ----------------------------------------------------------------------------
module flms_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  flms_pkg::cell_ctrl_t  ctrl,
    input  flms_pkg::tok_t        tok_in,
    output flms_pkg::tok_t        tok_out
);

    logic                                act_reg;
    logic signed [flms_pkg::COORD_W-1:0] lm_x_reg;
    logic signed [flms_pkg::COORD_W-1:0] lm_y_reg;

    flms_pkg::tok_t                      s1_tok_reg;
    flms_pkg::tok_t                      s2_tok_reg;
    flms_pkg::tok_t                      s3_tok_reg;
    flms_pkg::tok_t                      s3_tok_next;
    logic signed [flms_pkg::COORD_W:0]   dx_reg;
    logic signed [flms_pkg::COORD_W:0]   dy_reg;
    logic signed [flms_pkg::COORD_W:0]   dx_next;
    logic signed [flms_pkg::COORD_W:0]   dy_next;
    logic signed [2*flms_pkg::COORD_W+1:0] px;
    logic signed [2*flms_pkg::COORD_W+1:0] py;
    logic [flms_pkg::SQ_W-1:0]           sqx_reg;
    logic [flms_pkg::SQ_W-1:0]           sqy_reg;
    logic [flms_pkg::DIST_W-1:0]         sum;

    always_comb begin
        dx_next = {tok_in.x[flms_pkg::COORD_W-1], tok_in.x}
                - {lm_x_reg[flms_pkg::COORD_W-1], lm_x_reg};
        dy_next = {tok_in.y[flms_pkg::COORD_W-1], tok_in.y}
                - {lm_y_reg[flms_pkg::COORD_W-1], lm_y_reg};
        px      = dx_reg * dx_reg;
        py      = dy_reg * dy_reg;
        sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        s3_tok_next = s2_tok_reg;
        if (act_reg && (sum < s2_tok_reg.near_dist)) begin
            s3_tok_next.near_dist = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
        end else if (ctrl.clear) begin
            act_reg <= 1'b0;
        end else if (ctrl.load) begin
            act_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            lm_x_reg <= ctrl.x;
            lm_y_reg <= ctrl.y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tok_reg.valid <= 1'b0;
            s2_tok_reg.valid <= 1'b0;
            s3_tok_reg.valid <= 1'b0;
        end else begin
            s1_tok_reg <= tok_in;
            s2_tok_reg <= s1_tok_reg;
            s3_tok_reg <= s3_tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= px[flms_pkg::SQ_W-1:0];
        sqy_reg <= py[flms_pkg::SQ_W-1:0];
    end

    assign tok_out = s3_tok_reg;

endmodule

>>> rtl/farthest_point_landmark_select_core.sv
// ----------------------------------------------------------------------------
// farthest_point_landmark_select_core
// MaxMin landmark selection over loaded 2-D points using a chain of
// landmark cells fed from the point RAM.
// Load: one point item per cycle while in the load state. After the last point,
//   each landmark takes one RAM pass through the 64-cell chain, and a result
//   hand-off waits whenever the output register is still full.
// Results leave through a one-entry output register.
// Reset (aresetn, synchronous, active low) empties the store and cells and
// sets target_reg to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module farthest_point_landmark_select_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  flms_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output flms_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [flms_pkg::LM_CNT_W-1:0]     cfg_data
);

    flms_pkg::state_t                    state_reg;
    flms_pkg::state_t                    state_next;

    logic [flms_pkg::LM_CNT_W-1:0]       target_reg;
    logic [flms_pkg::LM_CNT_W-1:0]       tgt_eff;
    logic [flms_pkg::CNT_W-1:0]          n_reg;
    logic [flms_pkg::CNT_W-1:0]          rd_cnt_reg;
    logic [flms_pkg::CNT_W-1:0]          recv_cnt_reg;
    logic                                src_valid_reg;
    logic [flms_pkg::IDX_W-1:0]          src_idx_reg;
    logic [flms_pkg::PT_W-1:0]           rd_data;

    logic [flms_pkg::DIST_W-1:0]         best_reg;
    logic                                found_reg;
    logic [flms_pkg::IDX_W-1:0]          cand_idx_reg;
    logic signed [flms_pkg::COORD_W-1:0] cand_x_reg;
    logic signed [flms_pkg::COORD_W-1:0] cand_y_reg;
    logic [flms_pkg::LM_CNT_W-1:0]       count_reg;
    logic [flms_pkg::LM_CNT_W-1:0]       count_inc;
    logic [flms_pkg::IDX_W-1:0]          pend_idx_reg;

    logic                                m_valid_reg;
    flms_pkg::out_item_t                 m_data_reg;

    logic                                in_acc;
    logic                                store_wr;
    logic                                out_free;
    logic                                push_mid;
    logic                                push_final;
    logic                                adopt;
    logic                                rd_en;
    logic                                start_stream;

    flms_pkg::tok_t                      chain [flms_pkg::MAX_LANDMARKS+1];
    flms_pkg::cell_ctrl_t                cell_ctrl [flms_pkg::MAX_LANDMARKS];
    flms_pkg::tok_t                      tail;

    assign cfg_ready = 1'b1;
    assign count_inc = count_reg + flms_pkg::LM_CNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign tail      = chain[flms_pkg::MAX_LANDMARKS];

    always_comb begin
        if (target_reg == '0) begin
            tgt_eff = flms_pkg::LM_CNT_W'(1);
        end else if (target_reg > flms_pkg::LM_CNT_W'(flms_pkg::MAX_LANDMARKS)) begin
            tgt_eff = flms_pkg::LM_CNT_W'(flms_pkg::MAX_LANDMARKS);
        end else begin
            tgt_eff = target_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            flms_pkg::S_LOAD: begin
                if (s_valid && s_data.last_point) begin
                    state_next = flms_pkg::S_STREAM;
                end
            end
            flms_pkg::S_STREAM: begin
                if (recv_cnt_reg == n_reg) begin
                    state_next = flms_pkg::S_DECIDE;
                end
            end
            flms_pkg::S_DECIDE: begin
                if (!found_reg) begin
                    state_next = flms_pkg::S_FINAL;
                end else if (count_reg != '0) begin
                    state_next = flms_pkg::S_PUSH;
                end else begin
                    state_next = flms_pkg::S_ADOPT;
                end
            end
            flms_pkg::S_PUSH: begin
                if (out_free) begin
                    state_next = flms_pkg::S_ADOPT;
                end
            end
            flms_pkg::S_ADOPT: begin
                if (count_inc == tgt_eff) begin
                    state_next = flms_pkg::S_FINAL;
                end else begin
                    state_next = flms_pkg::S_STREAM;
                end
            end
            flms_pkg::S_FINAL: begin
                if (out_free) begin
                    state_next = flms_pkg::S_LOAD;
                end
            end
            default: state_next = flms_pkg::S_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = (state_reg == flms_pkg::S_LOAD);
        in_acc       = s_ready && s_valid;
        store_wr     = in_acc && (n_reg < flms_pkg::CNT_W'(flms_pkg::MAX_POINTS));
        push_mid     = (state_reg == flms_pkg::S_PUSH) && out_free;
        push_final   = (state_reg == flms_pkg::S_FINAL) && out_free;
        adopt        = (state_reg == flms_pkg::S_ADOPT);
        rd_en        = (state_reg == flms_pkg::S_STREAM) && (rd_cnt_reg < n_reg);
        start_stream = (in_acc && s_data.last_point) || (adopt && (count_inc != tgt_eff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= flms_pkg::S_LOAD;
            target_reg    <= flms_pkg::LM_CNT_W'(1);
            n_reg         <= '0;
            rd_cnt_reg    <= '0;
            recv_cnt_reg  <= '0;
            src_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            src_valid_reg <= rd_en;
            if (cfg_valid) begin
                target_reg <= cfg_data;
            end
            if (push_final) begin
                n_reg <= '0;
            end else if (store_wr) begin
                n_reg <= n_reg + flms_pkg::CNT_W'(1);
            end
            if (start_stream) begin
                rd_cnt_reg   <= '0;
                recv_cnt_reg <= '0;
                found_reg    <= 1'b0;
                best_reg     <= '0;
            end else begin
                if (rd_en) begin
                    rd_cnt_reg <= rd_cnt_reg + flms_pkg::CNT_W'(1);
                end
                if (tail.valid) begin
                    recv_cnt_reg <= recv_cnt_reg + flms_pkg::CNT_W'(1);
                    // strict compare keeps the lowest index on ties
                    if (tail.near_dist > best_reg) begin
                        best_reg  <= tail.near_dist;
                        found_reg <= 1'b1;
                    end
                end
            end
            if (push_final) begin
                count_reg <= '0;
            end else if (adopt) begin
                count_reg <= count_inc;
            end
            if (push_mid || push_final) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_idx_reg <= rd_cnt_reg[flms_pkg::IDX_W-1:0];
        if (!start_stream && tail.valid && (tail.near_dist > best_reg)) begin
            cand_idx_reg <= tail.idx;
            cand_x_reg   <= tail.x;
            cand_y_reg   <= tail.y;
        end
        if (adopt) begin
            pend_idx_reg <= cand_idx_reg;
        end
        if (push_mid) begin
            m_data_reg.landmark_index <= pend_idx_reg;
            m_data_reg.last_landmark  <= 1'b0;
        end else if (push_final) begin
            m_data_reg.landmark_index <= pend_idx_reg;
            m_data_reg.last_landmark  <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    flms_ram #(
        .WIDTH (flms_pkg::PT_W),
        .DEPTH (flms_pkg::MAX_POINTS)
    ) u_point_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (n_reg[flms_pkg::IDX_W-1:0]),
        .wr_data ({s_data.y_coord, s_data.x_coord}),
        .rd_addr (rd_cnt_reg[flms_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // head item: fresh point, distance not yet bounded by any landmark
    always_comb begin
        chain[0].valid     = src_valid_reg;
        chain[0].idx       = src_idx_reg;
        chain[0].x         = rd_data[flms_pkg::COORD_W-1:0];
        chain[0].y         = rd_data[flms_pkg::PT_W-1:flms_pkg::COORD_W];
        chain[0].near_dist = '1;
    end

    for (genvar j = 0; j < flms_pkg::MAX_LANDMARKS; j++) begin : g_cell
        always_comb begin
            cell_ctrl[j].clear = push_final;
            cell_ctrl[j].load  = adopt
                && (count_reg[flms_pkg::SLOT_W-1:0] == flms_pkg::SLOT_W'(j));
            cell_ctrl[j].x     = cand_x_reg;
            cell_ctrl[j].y     = cand_y_reg;
        end

        flms_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl[j]),
            .tok_in  (chain[j]),
            .tok_out (chain[j+1])
        );
    end

endmodule

>>> tb/sv/tb_farthest_point_landmark_select_core.sv
// ----------------------------------------------------------------------------
// tb_farthest_point_landmark_select_core
// Self-checking bench for the MaxMin landmark selector. Point sets are
// streamed in and a local farthest-point predictor queues the landmark
// indices each set should yield. Every result item is compared with the
// oldest queued landmark. Directed sets cover coordinate extremes, ties,
// single and duplicate points and target limits. Random sets follow, with and
// without sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_farthest_point_landmark_select_core;

    localparam int CYCLE_LIMIT   = 4000000;
    localparam int SETTLE_CYCLES = 16;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    flms_pkg::in_item_t            s_data    = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    flms_pkg::out_item_t           m_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [flms_pkg::LM_CNT_W-1:0] cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatch_count = 0;
    int sets_sent      = 0;
    int points_sent    = 0;
    int landmarks_seen = 0;

    logic [flms_pkg::LM_CNT_W-1:0]       landmark_goal = 7'd1;
    logic signed [flms_pkg::COORD_W-1:0] held_x [$];
    logic signed [flms_pkg::COORD_W-1:0] held_y [$];
    flms_pkg::out_item_t                 landmark_exp [$];

    farthest_point_landmark_select_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb_farthest_point_landmark_select_core NOT OK");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic longint span_sq(input logic signed [flms_pkg::COORD_W-1:0] ax, ay,
                                       bx, by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return (dx * dx + dy * dy) & 64'h1_FFFF_FFFF;
    endfunction

    // farthest-point selection over the held set; clears the set afterwards
    function automatic void predict_landmarks();
        longint              near_d [flms_pkg::MAX_POINTS];
        bit                  taken [flms_pkg::MAX_POINTS];
        int                  picks [$];
        int                  n;
        int                  goal;
        int                  pick;
        longint              best;
        longint              d;
        flms_pkg::out_item_t lm;
        n = held_x.size();
        goal = (landmark_goal == 0) ? 1 :
               (landmark_goal > flms_pkg::MAX_LANDMARKS) ? flms_pkg::MAX_LANDMARKS :
               int'(landmark_goal);
        for (int i = 0; i < n; i++) begin
            taken[i]  = 1'b0;
            near_d[i] = span_sq(held_x[i], held_y[i], held_x[0], held_y[0]);
        end
        taken[0] = 1'b1;
        picks.push_back(0);
        while (picks.size() < goal) begin
            best = 0;
            pick = -1;
            for (int i = 0; i < n; i++) begin
                if (!taken[i] && near_d[i] > best) begin
                    best = near_d[i];
                    pick = i;
                end
            end
            if (pick < 0) break;
            taken[pick] = 1'b1;
            picks.push_back(pick);
            for (int i = 0; i < n; i++) begin
                if (!taken[i]) begin
                    d = span_sq(held_x[i], held_y[i], held_x[pick], held_y[pick]);
                    if (d < near_d[i]) near_d[i] = d;
                end
            end
        end
        for (int k = 0; k < picks.size(); k++) begin
            lm.landmark_index = flms_pkg::IDX_W'(picks[k]);
            lm.last_landmark  = (k == picks.size() - 1);
            landmark_exp.push_back(lm);
        end
        held_x.delete();
        held_y.delete();
    endfunction

    always @(posedge aclk) begin
        flms_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            landmarks_seen++;
            if (landmark_exp.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected landmark: expected none, actual index %0d last %0b",
                         $time, m_data.landmark_index, m_data.last_landmark);
            end else begin
                want = landmark_exp.pop_front();
                if (m_data.landmark_index !== want.landmark_index) begin
                    mismatch_count++;
                    $display("%0t: landmark_index mismatch: expected %0d, actual %0d",
                             $time, want.landmark_index, m_data.landmark_index);
                end
                if (m_data.last_landmark !== want.last_landmark) begin
                    mismatch_count++;
                    $display("%0t: last_landmark mismatch: expected %0b, actual %0b",
                             $time, want.last_landmark, m_data.last_landmark);
                end
            end
        end
    end

    task automatic send_point(input logic signed [flms_pkg::COORD_W-1:0] px, py,
                              input logic end_of_set);
        flms_pkg::in_item_t item;
        item.x_coord    = px;
        item.y_coord    = py;
        item.last_point = end_of_set;
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        points_sent++;
        if (held_x.size() < flms_pkg::MAX_POINTS) begin
            held_x.push_back(px);
            held_y.push_back(py);
        end
        if (end_of_set) begin
            sets_sent++;
            predict_landmarks();
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (landmark_exp.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_target(input logic [flms_pkg::LM_CNT_W-1:0] goal);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= goal;
        do @(posedge aclk); while (!cfg_ready);
        landmark_goal = goal;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // spread 0: full range, 1: tiny box (ties, duplicates), 2: corners, axis extremes and origin
    task automatic send_random_set(input int n, input int spread);
        logic signed [flms_pkg::COORD_W-1:0] px;
        logic signed [flms_pkg::COORD_W-1:0] py;
        for (int i = 0; i < n; i++) begin
            case (spread)
                0: begin
                    px = flms_pkg::COORD_W'($urandom);
                    py = flms_pkg::COORD_W'($urandom);
                end
                1: begin
                    px = flms_pkg::COORD_W'($urandom_range(8));
                    py = flms_pkg::COORD_W'($urandom_range(8));
                    px = px - 16'sd4;
                    py = py - 16'sd4;
                end
                default: begin
                    case ($urandom_range(2))
                        0: px = 16'sh8000;
                        1: px = 16'sh7FFF;
                        default: px = '0;
                    endcase
                    case ($urandom_range(2))
                        0: py = 16'sh8000;
                        1: py = 16'sh7FFF;
                        default: py = '0;
                    endcase
                end
            endcase
            send_point(px, py, i == n - 1);
        end
    endtask

    task automatic test_reset_target();
        send_point(16'sd100, 16'sd100, 1'b0);
        send_point(-16'sd100, 16'sd50, 1'b0);
        send_point(16'sd7, -16'sd9, 1'b1);
    endtask

    task automatic test_coord_extremes();
        write_target(7'd127);
        send_point(16'sh8000, 16'sh8000, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b1);
    endtask

    task automatic test_equal_distance_ties();
        write_target(7'd4);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd10, 16'sd0, 1'b0);
        send_point(-16'sd10, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd10, 1'b0);
        send_point(16'sd0, -16'sd10, 1'b1);
    endtask

    task automatic test_single_point();
        send_point(-16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_duplicate_points();
        for (int i = 0; i < 4; i++) send_point(16'sd5, -16'sd5, i == 3);
    endtask

    task automatic test_zero_target();
        write_target(7'd0);
        send_point(16'sd1, 16'sd2, 1'b0);
        send_point(16'sd300, -16'sd200, 1'b0);
        send_point(-16'sd300, 16'sd200, 1'b1);
    endtask

    task automatic test_random_sets(input int send_pct, input int recv_pct, input int item_goal);
        int                            first;
        int                            n;
        int                            r;
        logic [flms_pkg::LM_CNT_W-1:0] goal_pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first = points_sent;
        while (points_sent - first < item_goal) begin
            if ($urandom_range(3) == 0) begin
                case ($urandom_range(5))
                    0: goal_pick = 7'd0;
                    1: goal_pick = 7'd127;
                    2: goal_pick = 7'd64;
                    3: goal_pick = 7'd1;
                    default: goal_pick = flms_pkg::LM_CNT_W'($urandom_range(20, 2));
                endcase
                write_target(goal_pick);
            end
            r = $urandom_range(39);
            if (r == 0) n = 1;
            else if (r == 1) n = $urandom_range(80, 60);
            else n = $urandom_range(12, 2);
            r = $urandom_range(9);
            send_random_set(n, (r < 6) ? 0 : (r < 8) ? 1 : 2);
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_target();
        test_coord_extremes();
        test_equal_distance_ties();
        test_single_point();
        test_duplicate_points();
        test_zero_target();
        test_random_sets(23, 78, 150);
        test_random_sets(78, 23, 150);
        test_random_sets(0, 0, 150);

        drain_results();
        $display("covered %0d point sets, %0d points, %0d landmarks checked",
                 sets_sent, points_sent, landmarks_seen);
        $display("targets 0..127 incl. saturation, ties, duplicates, stalls on both sides");
        if (mismatch_count == 0) begin
            $display("tb_farthest_point_landmark_select_core OK");
        end else begin
            $display("tb_farthest_point_landmark_select_core NOT OK");
        end
        $finish;
    end

endmodule
